// File: rtl/core/mach_pkg.sv
// shared types, constants and the arctangent table of the compass heading core
// no dependencies; compile first
package mach_pkg;

  localparam int unsigned RAW_W      = 16;
  localparam int unsigned DIFF_W     = 17;
  localparam int unsigned HEAD_W     = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;

  localparam int unsigned XY_W       = 20;
  localparam int unsigned ANG_W      = 26;
  localparam int unsigned ATAN_W     = 22;
  localparam int unsigned ATAN_LEN   = 24;
  localparam int unsigned STEP_IDX_W = 5;
  localparam int unsigned ROUND_SHIFT = 10;

  localparam logic signed [ANG_W-1:0] ANG_90     = 26'sd5898240;
  localparam logic signed [ANG_W-1:0] ANG_450    = 26'sd29491200;
  localparam logic signed [ANG_W-1:0] ROUND_HALF = 26'sd512;
  localparam logic [HEAD_W-1:0]       HEAD_FULL  = 15'd23040;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN_ADD,
    ST_DIV_LD,
    ST_DIV,
    ST_ROT,
    ST_STEP,
    ST_WRAP,
    ST_ROUND
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic wrap;
  } cordic_cmd_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/mach_if.sv
// valid/ready channel interfaces for magnetometer samples and headings
// depends on mach_pkg
interface mach_in_if;
  import mach_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] mag_x;
  logic signed [RAW_W-1:0] mag_y;

  modport source (output valid, output mag_x, output mag_y, input ready);
  modport sink (input valid, input mag_x, input mag_y, output ready);
endinterface

interface mach_out_if;
  import mach_pkg::*;

  logic              valid;
  logic              ready;
  logic [HEAD_W-1:0] heading;

  modport source (output valid, output heading, input ready);
  modport sink (input valid, input heading, output ready);
endinterface

// File: rtl/core/mach_window.sv
// sample ring with running x and y sums, read-old-then-write per item
// depends on mach_pkg
module mach_window #(
  parameter int unsigned WINDOW = 8,
  localparam int unsigned SUM_W = mach_pkg::RAW_W + $clog2(WINDOW) + 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               upd_i,
  input  logic                               add_i,
  input  logic signed [mach_pkg::DIFF_W-1:0] new_x_i,
  input  logic signed [mach_pkg::DIFF_W-1:0] new_y_i,
  output logic signed [SUM_W-1:0]            sum_x_o,
  output logic signed [SUM_W-1:0]            sum_y_o
);
  import mach_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  logic signed [DIFF_W-1:0] mem_x [WINDOW];
  logic signed [DIFF_W-1:0] mem_y [WINDOW];
  logic [WINDOW-1:0]        vld_q;
  logic [SLOT_W-1:0]        slot_q;
  logic                     old_vld_q;
  logic signed [DIFF_W-1:0] old_x_q, old_y_q, new_x_q, new_y_q;
  logic signed [SUM_W-1:0]  sum_x_q, sum_y_q;
  logic signed [SUM_W-1:0]  sub_x, sub_y;

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      old_x_q        <= mem_x[slot_q];
      old_y_q        <= mem_y[slot_q];
      mem_x[slot_q]  <= new_x_i;
      mem_y[slot_q]  <= new_y_i;
      new_x_q        <= new_x_i;
      new_y_q        <= new_y_i;
    end
  end

  // never-written slots count as zero
  assign sub_x = old_vld_q ? SUM_W'(old_x_q) : '0;
  assign sub_y = old_vld_q ? SUM_W'(old_y_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      slot_q    <= '0;
      old_vld_q <= 1'b0;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
    end else begin
      if (upd_i) begin
        old_vld_q     <= vld_q[slot_q];
        vld_q[slot_q] <= 1'b1;
        slot_q        <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
      end
      if (add_i) begin
        sum_x_q <= sum_x_q + SUM_W'(new_x_q) - sub_x;
        sum_y_q <= sum_y_q + SUM_W'(new_y_q) - sub_y;
      end
    end
  end

  assign sum_x_o = sum_x_q;
  assign sum_y_o = sum_y_q;

endmodule

// File: rtl/core/mach_div.sv
// divides both window sums by the window length through one shared reciprocal multiplier
// one lane per cycle, truncates toward zero; depends on mach_pkg
module mach_div #(
  parameter int unsigned WINDOW = 8,
  localparam int unsigned SUM_W = mach_pkg::RAW_W + $clog2(WINDOW) + 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [SUM_W-1:0]            sum_x_i,
  input  logic signed [SUM_W-1:0]            sum_y_i,
  output logic                               done_o,
  output logic signed [mach_pkg::DIFF_W-1:0] avg_x_o,
  output logic signed [mach_pkg::DIFF_W-1:0] avg_y_o
);
  import mach_pkg::*;

  localparam int unsigned RW      = $clog2(WINDOW);
  localparam int unsigned MAG_W   = SUM_W - 1;
  localparam int unsigned SHIFT   = MAG_W + RW;
  localparam int unsigned RECIP_W = MAG_W + 2;
  localparam int unsigned PROD_W  = MAG_W + RECIP_W;
  // ceil(2^SHIFT / WINDOW) gives the exact floor quotient for every magnitude
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW));
  localparam logic [1:0] LANES_INIT = 2'd2;

  logic signed [SUM_W-1:0]  sum_in [2];
  logic [MAG_W-1:0]         mag_in [2];
  logic [MAG_W-1:0]         mag_q  [2];
  logic                     neg_q  [2];
  logic [DIFF_W-2:0]        quo_q  [2];
  logic signed [DIFF_W-1:0] qv     [2];
  logic signed [DIFF_W-1:0] avg    [2];
  logic                     lane;
  logic [MAG_W-1:0]         mul_a;
  logic [PROD_W-1:0]        prod;
  logic [1:0]               cnt_q;

  assign sum_in[0] = sum_x_i;
  assign sum_in[1] = sum_y_i;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag_in[l] = sum_in[l][SUM_W-1] ? MAG_W'(-sum_in[l]) : MAG_W'(sum_in[l]);
      qv[l]     = {1'b0, quo_q[l]};
      avg[l]    = neg_q[l] ? -qv[l] : qv[l];
    end
  end

  // x lane first, then y lane
  assign lane  = (cnt_q == 2'd1);
  assign mul_a = mag_q[lane];
  assign prod  = PROD_W'(mul_a) * PROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int l = 0; l < 2; l++) begin
        mag_q[l] <= mag_in[l];
        neg_q[l] <= sum_in[l][SUM_W-1];
      end
    end else if (cnt_q != 2'd0) begin
      quo_q[lane] <= prod[SHIFT +: DIFF_W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= LANES_INIT;
    end else if (cnt_q != 2'd0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign done_o  = (cnt_q == 2'd1);
  assign avg_x_o = avg[0];
  assign avg_y_o = avg[1];

endmodule

// File: rtl/core/mach_cordic.sv
// iterative vectoring cordic for atan2, then heading wrap and rounding
// one micro-rotation per cycle; depends on mach_pkg
module mach_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mach_pkg::cordic_cmd_t              cmd_i,
  input  logic signed [mach_pkg::DIFF_W-1:0] avg_x_i,
  input  logic signed [mach_pkg::DIFF_W-1:0] avg_y_i,
  output logic                               last_step_o,
  output logic [mach_pkg::HEAD_W-1:0]        heading_o
);
  import mach_pkg::*;

  localparam int unsigned STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam logic [STEP_IDX_W-1:0] STEP_LAST = STEP_IDX_W'(STEPS - 1);

  logic signed [XY_W-1:0]  x_q, y_q, x_ext, y_ext, x_ld, y_ld, dx, dy;
  logic signed [ANG_W-1:0] z_q, z_ld, ang, z_eff, h_lo, h_hi, h_q, h_rnd;
  logic [STEP_IDX_W-1:0]   step_q;
  logic                    zero_q, y_pos;
  logic [HEAD_W-1:0]       hd;

  assign x_ext = XY_W'(avg_x_i);
  assign y_ext = XY_W'(avg_y_i);

  // left half plane turned by +-90 degrees first
  always_comb begin
    x_ld = x_ext;
    y_ld = y_ext;
    z_ld = '0;
    if (x_ext[XY_W-1]) begin
      if (!y_ext[XY_W-1]) begin
        x_ld = y_ext;
        y_ld = -x_ext;
        z_ld = ANG_90;
      end else begin
        x_ld = -y_ext;
        y_ld = x_ext;
        z_ld = -ANG_90;
      end
    end
  end

  assign dx    = y_q >>> step_q;
  assign dy    = x_q >>> step_q;
  assign ang   = {{(ANG_W - ATAN_W){1'b0}}, atan_lut(step_q)};
  assign y_pos = !y_q[XY_W-1] && (y_q != '0);

  assign z_eff = zero_q ? '0 : z_q;
  assign h_lo  = ANG_90 - z_eff;
  assign h_hi  = ANG_450 - z_eff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= x_ld;
      y_q    <= y_ld;
      z_q    <= z_ld;
      zero_q <= (avg_x_i == '0) && (avg_y_i == '0);
    end else if (cmd_i.step) begin
      if (y_pos) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + ang;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - ang;
      end
    end
    if (cmd_i.wrap) begin
      h_q <= h_lo[ANG_W-1] ? h_hi : h_lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.load) begin
      step_q <= '0;
    end else if (cmd_i.step) begin
      step_q <= step_q + 1'b1;
    end
  end

  // round half up, full turn wraps to zero
  assign h_rnd     = h_q + ROUND_HALF;
  assign hd        = h_rnd[HEAD_W+ROUND_SHIFT-1:ROUND_SHIFT];
  assign heading_o = (hd == HEAD_FULL) ? '0 : hd;

  assign last_step_o = (step_q == STEP_LAST);

endmodule

// File: rtl/core/mag_average_compass_heading_core.sv
// top level of the magnetometer compass heading core
// depends on mach_pkg, mach_if, mach_window, mach_div, mach_cordic
//
// usage: raw (mag_x, mag_y) items enter on in_if; each gives one heading item on
// out_if in 1/64 degree, 0..23039, computed as 90 - atan2 of the window averages.
// origin_x / origin_y are written through cfg_we_i, cfg_idx_i, cfg_data_i while idle;
// the user must keep to this; the block does not enforce it. one item at a time:
// in_if.ready is high only while the sequencer is idle. an item passes through the
// window update, the divider load, the reciprocal multiply (one lane per cycle), the
// cordic load, one micro-rotation per cycle, the heading wrap and rounding into the
// output register; in_if.ready returns in the same cycle that out_if.valid rises.
// the output register holds a heading until taken; if it is still full when the next
// heading is ready, the sequencer waits, and no new item is taken meanwhile.
// reset clears the origins, the window (all slots read as zero until written),
// the sums and the output valid; no clearing pass is needed.
module mag_average_compass_heading_core #(
  parameter int unsigned WINDOW       = 8,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mach_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mach_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  mach_in_if.sink                            in_if,
  mach_out_if.source                         out_if
);
  import mach_pkg::*;

  localparam int unsigned SUM_W = RAW_W + $clog2(WINDOW) + 1;

  state_e                   state_q, state_d;
  logic signed [RAW_W-1:0]  origin_x_q, origin_y_q;
  logic signed [DIFF_W-1:0] diff_x, diff_y, avg_x, avg_y;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic                     in_acc, win_add, div_start, div_done, last_step, out_load;
  cordic_cmd_t              cmd;
  logic [HEAD_W-1:0]        heading_c, heading_q;
  logic                     out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: origin_x_q <= signed'(cfg_data_i);
        REG_ORIGIN_Y: origin_y_q <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign diff_x      = DIFF_W'(in_if.mag_x) - DIFF_W'(origin_x_q);
  assign diff_y      = DIFF_W'(in_if.mag_y) - DIFF_W'(origin_y_q);

  mach_window #(.WINDOW(WINDOW)) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (in_acc),
    .add_i   (win_add),
    .new_x_i (diff_x),
    .new_y_i (diff_y),
    .sum_x_o (sum_x),
    .sum_y_o (sum_y)
  );

  mach_div #(.WINDOW(WINDOW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_x_i (sum_x),
    .sum_y_i (sum_y),
    .done_o  (div_done),
    .avg_x_o (avg_x),
    .avg_y_o (avg_y)
  );

  mach_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .avg_x_i     (avg_x),
    .avg_y_i     (avg_y),
    .last_step_o (last_step),
    .heading_o   (heading_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    win_add   = 1'b0;
    div_start = 1'b0;
    cmd       = '0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_WIN_ADD;
      end
      ST_WIN_ADD: begin
        win_add = 1'b1;
        state_d = ST_DIV_LD;
      end
      ST_DIV_LD: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_ROT;
      end
      ST_ROT: begin
        cmd.load = 1'b1;
        state_d  = ST_STEP;
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (last_step) state_d = ST_WRAP;
      end
      ST_WRAP: begin
        cmd.wrap = 1'b1;
        state_d  = ST_ROUND;
      end
      ST_ROUND: begin
        if (!out_valid_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) heading_q <= heading_c;
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.heading = heading_q;

  a_out_from_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_ROUND)
    else $error("heading valid without finishing an item");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> heading_q < HEAD_FULL)
    else $error("heading outside a full turn");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_WIN_ADD)
    else $error("accepted item did not start the window update");

endmodule
